@@ sv/ascii_hex_frame_float_decoder_unit_defines.svh @@
// Assertion macros shared by the decoder project
`ifndef ASCII_HEX_FRAME_FLOAT_DECODER_UNIT_DEFINES_SVH
`define ASCII_HEX_FRAME_FLOAT_DECODER_UNIT_DEFINES_SVH

// Check a consequence in the same cycle
`define AHFD_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle
`define AHFD_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ahfd_pkg.sv @@
`timescale 1ns / 1ps

package ahfd_pkg;

  // Frame limits and field positions
  localparam logic [7:0] MAX_FRAME    = 8'd128;
  localparam logic [7:0] MIN_FRAME    = 8'd33;
  localparam logic [7:0] F1_START     = 8'd7;
  localparam logic [7:0] F2_START     = 8'd23;
  localparam logic [7:0] FIELD_DIGITS = 8'd8;

  // Terminator characters
  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_LF = 8'h0A;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_CSUM  = 3'd1,
    ST_SHORT = 3'd2,
    ST_HEX   = 3'd3,
    ST_OVF   = 3'd4
  } ahfd_status_t;

  // Control that travels beside the converter stages
  typedef struct packed {
    logic         valid;
    ahfd_status_t status;
    logic [7:0]   len;
  } ahfd_ctl_t;

  // Converter pipeline depth
  localparam int CONV_STAGES = 4;

endpackage

@@ sv/ascii_hex_frame_float_decoder_unit.sv @@
`timescale 1ns / 1ps
// After its terminator word is accepted, a result passes the frame register,
// four converter stages and then the output register.
// Throughput: one word per cycle; input stalls only while a result waits in the
// output register and the next result has reached the last converter stage.
// Reset: synchronous active-low rst_n clears the frame state and all valid bits.
`include "ascii_hex_frame_float_decoder_unit_defines.svh"

module ascii_hex_frame_float_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_first_channel,
  output logic signed [15:0] out_second_channel,
  output logic [7:0]         out_frame_length
);

  logic                   en;
  logic                   fire;
  logic                   take;
  ahfd_pkg::ahfd_ctl_t    ctl0;
  ahfd_pkg::ahfd_ctl_t    ctl_r [ahfd_pkg::CONV_STAGES];
  logic [31:0]            bits1;
  logic [31:0]            bits2;
  logic signed [15:0]     ch1;
  logic signed [15:0]     ch2;
  logic                   ok;
  logic                   res_valid_r;
  ahfd_pkg::ahfd_status_t res_status_r;
  logic signed [15:0]     res_ch1_r;
  logic signed [15:0]     res_ch2_r;
  logic [7:0]             res_len_r;
  logic                   res_ok;
  logic                   res_err;
  logic                   res_ovf;
  logic                   chan_zero;

  // Load the output register when it is empty or being read
  assign take     = !res_valid_r || out_ready;
  // Advance unless the last stage holds a result that cannot move on
  assign en       = !ctl_r[ahfd_pkg::CONV_STAGES-1].valid || take;
  assign in_ready = en;
  assign fire     = in_valid && en;

  ahfd_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .fire    (fire),
    .rx_byte (in_rx_byte),
    .ctl_r   (ctl0),
    .bits1_r (bits1),
    .bits2_r (bits2)
  );

  ahfd_conv u_conv1 (.clk(clk), .en(en), .raw(bits1), .res_r(ch1));
  ahfd_conv u_conv2 (.clk(clk), .en(en), .raw(bits2), .res_r(ch2));

  // Carry status and length beside the converters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ahfd_pkg::CONV_STAGES; i++) ctl_r[i] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl0;
      for (int i = 1; i < ahfd_pkg::CONV_STAGES; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  // Register the result word, zeroing channels on error
  assign ok = ctl_r[ahfd_pkg::CONV_STAGES-1].status == ahfd_pkg::ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r  <= 1'b0;
      res_status_r <= ahfd_pkg::ST_OK;
      res_ch1_r    <= 16'sd0;
      res_ch2_r    <= 16'sd0;
      res_len_r    <= 8'd0;
    end else if (take) begin
      res_valid_r  <= ctl_r[ahfd_pkg::CONV_STAGES-1].valid;
      res_status_r <= ctl_r[ahfd_pkg::CONV_STAGES-1].status;
      res_ch1_r    <= ok ? ch1 : 16'sd0;
      res_ch2_r    <= ok ? ch2 : 16'sd0;
      res_len_r    <= ctl_r[ahfd_pkg::CONV_STAGES-1].len;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_status         = res_status_r;
  assign out_frame_length   = res_len_r;
  assign out_first_channel  = res_ch1_r;
  assign out_second_channel = res_ch2_r;

  // Terms for the checks below
  assign res_ok    = out_valid && (out_status == ahfd_pkg::ST_OK);
  assign res_err   = out_valid && (out_status != ahfd_pkg::ST_OK);
  assign res_ovf   = out_valid && (out_status == ahfd_pkg::ST_OVF);
  assign chan_zero = (out_first_channel == 16'sd0) && (out_second_channel == 16'sd0);

  `AHFD_ASSERT_NOW(a_err_zero, res_err, chan_zero, "channels not zero on error")
  `AHFD_ASSERT_NOW(a_ok_len, res_ok, out_frame_length >= ahfd_pkg::MIN_FRAME, "short ok frame")
  `AHFD_ASSERT_NOW(a_ovf_len, res_ovf, out_frame_length == ahfd_pkg::MAX_FRAME, "bad ovf length")
  `AHFD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid, "word dropped in stall")

endmodule

@@ sv/ahfd_frame.sv @@
`timescale 1ns / 1ps

module ahfd_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  output ahfd_pkg::ahfd_ctl_t ctl_r,
  output logic [31:0]         bits1_r,
  output logic [31:0]         bits2_r
);

  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  l0_r, l0_nxt;
  logic [7:0]  l1_r, l1_nxt;
  logic [31:0] f1_r, f1_nxt;
  logic [31:0] f2_r, f2_nxt;
  logic        hex_r, hex_nxt;
  logic        ovf_r, ovf_nxt;
  ahfd_pkg::ahfd_ctl_t ctl_nxt;

  logic        term;
  logic [7:0]  chk;
  logic [4:0]  hv;
  logic        in_f1;
  logic        in_f2;

  // Decode one hex digit: bit 4 flags a valid digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  // Encode a nibble as an uppercase hex character
  function automatic logic [7:0] hex_chr(input logic [3:0] n);
    logic [7:0] r;
    r = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    return r;
  endfunction

  assign term  = (rx_byte == ahfd_pkg::CHR_CR) || (rx_byte == ahfd_pkg::CHR_LF);
  assign chk   = sum_r - l0_r - l1_r;
  assign hv    = hex_val(rx_byte);
  assign in_f1 = (cnt_r >= ahfd_pkg::F1_START) &&
                 (cnt_r < ahfd_pkg::F1_START + ahfd_pkg::FIELD_DIGITS);
  assign in_f2 = (cnt_r >= ahfd_pkg::F2_START) &&
                 (cnt_r < ahfd_pkg::F2_START + ahfd_pkg::FIELD_DIGITS);

  // Frame state and terminator handling
  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    l0_nxt  = l0_r;
    l1_nxt  = l1_r;
    f1_nxt  = f1_r;
    f2_nxt  = f2_r;
    hex_nxt = hex_r;
    ovf_nxt = ovf_r;
    ctl_nxt = '0;
    ctl_nxt.status = ahfd_pkg::ST_OK;
    ctl_nxt.len    = cnt_r;
    if (fire) begin
      if (term) begin
        cnt_nxt = '0;
        sum_nxt = '0;
        l0_nxt  = '0;
        l1_nxt  = '0;
        f1_nxt  = '0;
        f2_nxt  = '0;
        hex_nxt = 1'b0;
        ovf_nxt = 1'b0;
        ctl_nxt.valid = (cnt_r != 8'd0) || ovf_r;
        priority if (ovf_r) ctl_nxt.status = ahfd_pkg::ST_OVF;
        else if (cnt_r < ahfd_pkg::MIN_FRAME) ctl_nxt.status = ahfd_pkg::ST_SHORT;
        else if (l0_r != hex_chr(chk[7:4]) || l1_r != hex_chr(chk[3:0]))
          ctl_nxt.status = ahfd_pkg::ST_CSUM;
        else if (hex_r) ctl_nxt.status = ahfd_pkg::ST_HEX;
        else ctl_nxt.status = ahfd_pkg::ST_OK;
      end else begin
        sum_nxt = sum_r + rx_byte;
        l0_nxt  = l1_r;
        l1_nxt  = rx_byte;
        if (cnt_r >= ahfd_pkg::MAX_FRAME) begin
          ovf_nxt = 1'b1;
        end else begin
          if (in_f1) begin
            f1_nxt = {f1_r[27:0], hv[3:0]};
            if (!hv[4]) hex_nxt = 1'b1;
          end else if (in_f2) begin
            f2_nxt = {f2_r[27:0], hv[3:0]};
            if (!hv[4]) hex_nxt = 1'b1;
          end
          cnt_nxt = cnt_r + 8'd1;
        end
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      l0_r  <= '0;
      l1_r  <= '0;
      f1_r  <= '0;
      f2_r  <= '0;
      hex_r <= 1'b0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      l0_r  <= l0_nxt;
      l1_r  <= l1_nxt;
      f1_r  <= f1_nxt;
      f2_r  <= f2_nxt;
      hex_r <= hex_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // Advance the frame result into the converter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bits1_r <= f1_r;
      bits2_r <= f2_r;
    end
  end

endmodule

@@ sv/ahfd_conv.sv @@
`timescale 1ns / 1ps

// Four-stage single to tenths converter: exact add of 0.01, round to double,
// times ten, round, truncate and saturate.
module ahfd_conv (
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       raw,
  output logic signed [15:0] res_r
);

  typedef enum logic [1:0] {
    K_ZERO = 2'd0,
    K_SAT  = 2'd1,
    K_NUM  = 2'd2
  } kind_t;

  // 0.01 as a double mantissa, fixed point with LSB 2^-59
  localparam logic [72:0] CONV_C = 73'h147AE147AE147B;

  // Stage 1: byte swap, classify, exact sum
  logic [31:0] bits;
  logic [7:0]  ex;
  logic [5:0]  shamt;
  logic [72:0] fx;
  kind_t       kind_nxt;
  logic [72:0] a_nxt;
  kind_t       k1_r;
  logic        s1_r;
  logic [72:0] a_r;

  assign bits  = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
  assign ex    = bits[30:23];
  assign shamt = 6'(ex - 8'd91);
  assign fx    = 73'({1'b1, bits[22:0]}) << shamt;
  assign a_nxt = bits[31] ? (fx - CONV_C) : (fx + CONV_C);

  always_comb begin
    priority if (ex == 8'd255 && bits[22:0] != 23'd0) kind_nxt = K_ZERO;
    else if (ex >= 8'd140) kind_nxt = K_SAT;
    else if (ex < 8'd121) kind_nxt = K_ZERO;
    else kind_nxt = K_NUM;
  end

  // Stage 2: find the leading one and round to 53 bits
  logic [6:0]  ld;
  logic [4:0]  shl;
  logic [72:0] nrm;
  logic        inc2;
  logic [53:0] ms_nxt;
  kind_t       k2_r;
  logic        s2_r;
  logic [6:0]  ld2_r;
  logic [53:0] ms_r;

  always_comb begin
    ld = 7'd51;
    for (int i = 51; i <= 72; i++) begin
      if (a_r[i]) ld = 7'(i);
    end
  end

  assign shl    = 5'(7'd72 - ld);
  assign nrm    = a_r << shl;
  assign inc2   = nrm[19] & ((|nrm[18:0]) | nrm[20]);
  assign ms_nxt = {1'b0, nrm[72:20]} + {53'd0, inc2};

  // Stage 3: times ten by shift and add
  logic [56:0] p_nxt;
  kind_t       k3_r;
  logic        s3_r;
  logic [6:0]  ld3_r;
  logic [56:0] p_r;

  assign p_nxt = (57'(ms_r) << 3) + (57'(ms_r) << 1);

  // Stage 4: round, truncate, saturate
  logic [52:0] m4;
  logic        g4;
  logic        st4;
  logic [6:0]  sh4;
  logic [53:0] q;
  logic [6:0]  sr;
  logic [53:0] mag;
  logic        big;
  logic signed [15:0] res_nxt;

  always_comb begin
    if (p_r[56]) begin
      m4  = p_r[56:4];
      g4  = p_r[3];
      st4 = |p_r[2:0];
      sh4 = 7'd4;
    end else begin
      m4  = p_r[55:3];
      g4  = p_r[2];
      st4 = |p_r[1:0];
      sh4 = 7'd3;
    end
  end

  assign q   = {1'b0, m4} + {53'd0, g4 & (st4 | m4[0])};
  assign sr  = 7'd111 - ld3_r - sh4;
  assign mag = q >> sr;
  assign big = |mag[53:15];

  always_comb begin
    unique case (k3_r)
      K_SAT:   res_nxt = s3_r ? 16'sh8000 : 16'sh7FFF;
      K_NUM: begin
        if (big) res_nxt = s3_r ? 16'sh8000 : 16'sh7FFF;
        else if (s3_r) res_nxt = -$signed({1'b0, mag[14:0]});
        else res_nxt = $signed({1'b0, mag[14:0]});
      end
      default: res_nxt = 16'sd0;
    endcase
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      k1_r  <= kind_nxt;
      s1_r  <= bits[31];
      a_r   <= a_nxt;
      k2_r  <= k1_r;
      s2_r  <= s1_r;
      ld2_r <= ld;
      ms_r  <= ms_nxt;
      k3_r  <= k2_r;
      s3_r  <= s2_r;
      ld3_r <= ld2_r;
      p_r   <= p_nxt;
      res_r <= res_nxt;
    end
  end

endmodule
